>>> rtl/keyboard_display_pia_top_macros.svh
// Assertion helpers for the file that checks itself.
`ifndef KEYBOARD_DISPLAY_PIA_TOP_MACROS_SVH
`define KEYBOARD_DISPLAY_PIA_TOP_MACROS_SVH

// Checked on every rising clock edge, quiet while reset is held.
`define KDP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define KDP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/kdp_pkg.sv
package kdp_pkg;

  typedef enum logic [1:0] {
    FUNC_BUS_READ  = 2'd0,
    FUNC_BUS_WRITE = 2'd1,
    FUNC_KEY_IN    = 2'd2,
    FUNC_DISP_TAKE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    SEL_KEY_DATA  = 2'd0,
    SEL_KEY_CTRL  = 2'd1,
    SEL_DISP_DATA = 2'd2,
    SEL_DISP_CTRL = 2'd3
  } sel_e;

  localparam logic [7:0] KeyLowerA   = 8'h61;
  localparam logic [7:0] KeyLowerZ   = 8'h7a;
  localparam logic [7:0] KeyCaseMask = 8'hdf;
  localparam logic [7:0] KeyBit7     = 8'h80;
  localparam logic [7:0] KeyBs       = 8'h08;
  localparam logic [7:0] KeyDel      = 8'h7f;
  localparam logic [7:0] KeyRubout   = 8'hdf;

  localparam logic [6:0] DispCr       = 7'h0d;
  localparam logic [6:0] DispCtrlMax  = 7'h1f;
  localparam logic [6:0] DispLowBase  = 7'h60;
  localparam logic [6:0] DispUpMask   = 7'h5f;

  // Terminal key to the machine's keyboard code.
  function automatic logic [7:0] key_to_machine(input logic [7:0] k);
    logic [7:0] r;
    if (k >= KeyLowerA && k <= KeyLowerZ) begin
      r = (k & KeyCaseMask) | KeyBit7;
    end else if (k == KeyBs || k == KeyDel) begin
      r = KeyRubout;
    end else begin
      r = k | KeyBit7;
    end
    return r;
  endfunction

  // Queued byte to the display's uppercase character set; control codes other than carriage return become zero.
  function automatic logic [6:0] char_to_display(input logic [7:0] c);
    logic [6:0] v;
    logic [6:0] r;
    v = c[6:0];
    if (v == DispCr) begin
      r = v;
    end else if (v <= DispCtrlMax) begin
      r = '0;
    end else if (v >= DispLowBase) begin
      r = v & DispUpMask;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> rtl/kdp_intf.sv
interface kdp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [1:0] reg_select;
  logic [7:0] write_data;
  logic [7:0] key_code;

  modport source (output valid, output func, output reg_select, output write_data,
                  output key_code, input ready);
  modport sink   (input valid, input func, input reg_select, input write_data,
                  input key_code, output ready);
endinterface

interface kdp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       key_accepted;
  logic       char_valid;
  logic [6:0] char_out;

  modport source (output valid, output read_data, output key_accepted,
                  output char_valid, output char_out, input ready);
  modport sink   (input valid, input read_data, input key_accepted,
                  input char_valid, input char_out, output ready);
endinterface

>>> rtl/keyboard_display_pia_top.sv
// Keyboard and display parallel port with four registers. Every beat on in_i is one event:
// a bus read, a bus write, a key arriving, or the display taking its queued character,
// and every such beat yields exactly one result beat on out_o, in order. Keys wait in a
// FIFO of KEY_FIFO_DEPTH entries held in a memory; a read of the key data register pops
// the oldest key, converted to uppercase with bit 7 set (backspace and delete read as
// 0xDF). The control and status registers report pending data in bit 7. A display data
// write queues one character when the slot is empty, but only once the display control
// register has been written. The block takes one beat every clock cycle while out_o is
// ready. A beat is captured in the input register and worked in the single combinational
// pass between the input register and the result register, which drives out_o. A result
// that waits on out_o holds the input register and so stops in_i as well. The oldest key
// is kept prefetched from the FIFO memory's registered read port, so a pop never waits
// for the memory. The FIFO needs no clearing pass after reset.
`include "keyboard_display_pia_top_macros.svh"

module keyboard_display_pia_top #(
  parameter int unsigned KEY_FIFO_DEPTH = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kdp_in_if.sink    in_i,
  kdp_out_if.source out_o
);

  localparam int unsigned AW = (KEY_FIFO_DEPTH > 1) ? $clog2(KEY_FIFO_DEPTH) : 1;
  localparam int unsigned CW = $clog2(KEY_FIFO_DEPTH + 1);

  typedef struct packed {
    kdp_pkg::func_e func;
    kdp_pkg::sel_e  reg_select;
    logic [7:0]     write_data;
    logic [7:0]     key_code;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       key_accepted;
    logic       char_valid;
    logic [6:0] char_out;
  } result_t;

  // Input stage.
  logic  s1_valid_q;
  item_t s1_q;
  logic  s1_adv;
  logic  in_take;

  // Result stage.
  logic    out_valid_q;
  result_t out_q;
  result_t res_d;

  // Architectural state.
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [7:0]    kdata_q, kdata_d;
  logic [7:0]    kctrl_q, kctrl_d;
  logic [7:0]    ddata_q, ddata_d;
  logic [7:0]    dctrl_q, dctrl_d;
  logic [7:0]    slot_q, slot_d;
  logic          full_q, full_d;
  logic          pen_q, pen_d;

  // Key FIFO memory and its prefetched front entry.
  logic [7:0]    key_mem [KEY_FIFO_DEPTH];
  logic [7:0]    front_q;
  logic          push, pop;

  function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
    return (i == AW'(KEY_FIFO_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // The input register moves on whenever the result register is empty or is being
  // drained in this cycle, so a stalled result only holds up the item behind it.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q.func       <= kdp_pkg::func_e'(in_i.func);
      s1_q.reg_select <= kdp_pkg::sel_e'(in_i.reg_select);
      s1_q.write_data <= in_i.write_data;
      s1_q.key_code   <= in_i.key_code;
    end
  end

  // The single pass: one event against the register file, giving next state and result.
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    kdata_d = kdata_q;
    kctrl_d = kctrl_q;
    ddata_d = ddata_q;
    dctrl_d = dctrl_q;
    slot_d  = slot_q;
    full_d  = full_q;
    pen_d   = pen_q;
    push    = 1'b0;
    pop     = 1'b0;
    res_d   = '0;
    if (s1_adv) begin
      unique case (s1_q.func)
        kdp_pkg::FUNC_BUS_READ: begin
          unique case (s1_q.reg_select)
            kdp_pkg::SEL_KEY_DATA: begin
              // An empty FIFO leaves the last key in place.
              if (count_q != '0) begin
                kdata_d = kdp_pkg::key_to_machine(front_q);
                head_d  = next_idx(head_q);
                pop     = 1'b1;
              end
              res_d.read_data = kdata_d;
            end
            kdp_pkg::SEL_KEY_CTRL: begin
              kctrl_d         = {count_q != '0, kctrl_q[6:0]};
              res_d.read_data = kctrl_d;
            end
            kdp_pkg::SEL_DISP_DATA: begin
              ddata_d         = {full_q, ddata_q[6:0]};
              res_d.read_data = ddata_d;
            end
            kdp_pkg::SEL_DISP_CTRL: begin
              // The old value is returned and bit 7 cleared afterwards.
              res_d.read_data = dctrl_q;
              dctrl_d         = {1'b0, dctrl_q[6:0]};
            end
            default: ;
          endcase
        end
        kdp_pkg::FUNC_BUS_WRITE: begin
          unique case (s1_q.reg_select)
            kdp_pkg::SEL_KEY_DATA:  kdata_d = s1_q.write_data;
            kdp_pkg::SEL_KEY_CTRL:  kctrl_d = s1_q.write_data;
            kdp_pkg::SEL_DISP_DATA: begin
              ddata_d = s1_q.write_data;
              if (pen_q && !full_q) begin
                slot_d = s1_q.write_data;
                full_d = 1'b1;
              end
            end
            kdp_pkg::SEL_DISP_CTRL: begin
              dctrl_d = s1_q.write_data;
              pen_d   = 1'b1;
            end
            default: ;
          endcase
        end
        kdp_pkg::FUNC_KEY_IN: begin
          if (count_q != CW'(KEY_FIFO_DEPTH)) begin
            tail_d             = next_idx(tail_q);
            push               = 1'b1;
            res_d.key_accepted = 1'b1;
          end
        end
        kdp_pkg::FUNC_DISP_TAKE: begin
          if (full_q) begin
            res_d.char_valid = 1'b1;
            res_d.char_out   = kdp_pkg::char_to_display(slot_q);
            full_d           = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // One event pushes or pops, never both.
  assign count_d = push ? count_q + 1'b1 : (pop ? count_q - 1'b1 : count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      kdata_q <= '0;
      kctrl_q <= '0;
      ddata_q <= '0;
      dctrl_q <= '0;
      full_q  <= 1'b0;
      pen_q   <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      kdata_q <= kdata_d;
      kctrl_q <= kctrl_d;
      ddata_q <= ddata_d;
      dctrl_q <= dctrl_d;
      full_q  <= full_d;
      pen_q   <= pen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  // The read port always fetches the entry at the next head, so front_q holds the
  // oldest key whenever the FIFO is not empty. A key written into an empty FIFO lands
  // at that very address and is forwarded past the memory.
  always_ff @(posedge clk_i) begin
    if (push) begin
      key_mem[tail_q] <= s1_q.key_code;
    end
    if (push && tail_q == head_d) begin
      front_q <= s1_q.key_code;
    end else begin
      front_q <= key_mem[head_d];
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.read_data    = out_q.read_data;
  assign out_o.key_accepted = out_q.key_accepted;
  assign out_o.char_valid   = out_q.char_valid;
  assign out_o.char_out     = out_q.char_out;

  // A key beat that meets a full FIFO, and a display take, as they leave the input stage.
  logic key_full_in;
  logic disp_take;

  assign key_full_in = s1_adv && s1_q.func == kdp_pkg::FUNC_KEY_IN &&
                       count_q == CW'(KEY_FIFO_DEPTH);
  assign disp_take   = s1_adv && s1_q.func == kdp_pkg::FUNC_DISP_TAKE;

  `KDP_ASSERT(a_count_in_range, count_q <= CW'(KEY_FIFO_DEPTH), "key count beyond depth")
  `KDP_ASSERT(a_empty_aligned, (count_q == '0) |-> (head_q == tail_q), "empty FIFO misaligned")
  `KDP_ASSERT(a_full_drops, key_full_in |=> !out_q.key_accepted, "key taken into a full FIFO")
  `KDP_ASSERT(a_take_reports, disp_take |=> out_q.char_valid == $past(full_q), "slot mismatch")
  `KDP_ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> (!out_valid_q && !s1_valid_q), "valid in reset")

endmodule
